@@ rtl/tpq_pkg.sv @@
// Package for the task priority queue: item structs, kind codes, widths.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int DATA_BITS_DEF = 32;
    localparam int CAP_W         = 5;
    localparam int OCC_W         = 5;
    localparam int TASK_W        = 8;
    localparam int PRIO_W        = 8;
    localparam int WORD_W        = 32;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_EXTRACT = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;
    localparam logic [1:0] KIND_REMOVE  = 2'd3;

    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] priority_req;
        logic [WORD_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [TASK_W-1:0] out_task;
        logic [WORD_W-1:0] out_data;
        logic [OCC_W-1:0]  occupancy;
    } t_out_item;

    // engine -> top result handoff
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

@@ rtl/tpq_engine.sv @@
// Queue engine: entry memory plus the sequencer for insert, scan and compaction.
// Depends on tpq_pkg.
`timescale 1ns / 1ps

module tpq_engine #(
    parameter int DEPTH     = tpq_pkg::DEPTH_DEF,
    parameter int DATA_BITS = tpq_pkg::DATA_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  tpq_pkg::t_in_item            i_in_item,
    output logic                         o_busy,
    input  logic [tpq_pkg::CAP_W-1:0]    i_cap,
    input  logic                         i_res_ready,
    output tpq_pkg::t_result             o_res
);
    import tpq_pkg::*;

    localparam int IDXW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PACK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    typedef struct packed {
        logic [TASK_W-1:0]    task_id;
        logic [PRIO_W-1:0]    prio;
        logic [DATA_BITS-1:0] data;
    } t_entry;

    t_entry mem [DEPTH];
    t_entry r_rdata;

    logic [1:0]           r_state, n_state;
    logic [CNTW-1:0]      r_fill, n_fill;
    logic [1:0]           r_kind, n_kind;
    logic [TASK_W-1:0]    r_tid, n_tid;
    logic [CNTW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]      r_wr_ptr, n_wr_ptr;
    logic                 r_pv, n_pv;
    logic [IDXW-1:0]      r_pidx, n_pidx;
    logic [IDXW-1:0]      r_best_idx, n_best_idx;
    logic [PRIO_W-1:0]    r_best_prio, n_best_prio;
    logic [TASK_W-1:0]    r_best_task, n_best_task;
    logic [DATA_BITS-1:0] r_best_data, n_best_data;
    logic                 r_ok, n_ok;

    logic            rd_en;
    logic [IDXW-1:0] rd_addr;
    logic            we;
    logic [IDXW-1:0] waddr;
    t_entry          wdata;
    logic            pass_end;
    logic            room;
    logic            drop;
    logic            hit;

    assign pass_end = (r_rd_ptr == r_fill) && !r_pv;
    assign rd_en    = ((r_state == S_SCAN) || (r_state == S_PACK)) && (r_rd_ptr < r_fill);
    assign rd_addr  = r_rd_ptr[IDXW-1:0];
    assign room     = (32'(r_fill) < 32'(i_cap)) && (r_fill < CNTW'(DEPTH));
    assign hit      = (r_rdata.task_id == r_tid);
    assign drop     = (r_kind == KIND_EXTRACT) ? (r_pidx == r_best_idx) : hit;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_kind      = r_kind;
        n_tid       = r_tid;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_best_idx  = r_best_idx;
        n_best_prio = r_best_prio;
        n_best_task = r_best_task;
        n_best_data = r_best_data;
        n_ok        = r_ok;
        we          = 1'b0;
        waddr       = r_wr_ptr[IDXW-1:0];
        wdata       = r_rdata;

        if (rd_en) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
            n_pv     = 1'b1;
            n_pidx   = rd_addr;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = i_in_item.kind;
                    n_tid    = i_in_item.task_id;
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    n_ok     = 1'b0;
                    case (i_in_item.kind)
                        KIND_INSERT: begin
                            n_state = S_DONE;
                            if (room) begin
                                we     = 1'b1;
                                waddr  = r_fill[IDXW-1:0];
                                wdata  = '{task_id: i_in_item.task_id,
                                           prio:    i_in_item.priority_req,
                                           data:    DATA_BITS'(i_in_item.payload)};
                                n_fill = r_fill + 1'b1;
                                n_ok   = 1'b1;
                            end
                        end
                        KIND_REMOVE: n_state = S_PACK;
                        default:     n_state = S_SCAN;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_pv) begin
                    if (r_kind == KIND_QUERY) begin
                        if (hit) n_ok = 1'b1;
                    end else if ((r_pidx == '0) || (r_rdata.prio > r_best_prio)) begin
                        n_best_idx  = r_pidx;
                        n_best_prio = r_rdata.prio;
                        n_best_task = r_rdata.task_id;
                        n_best_data = r_rdata.data;
                    end
                end
                if (pass_end) begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    if ((r_kind == KIND_EXTRACT) && (r_fill != '0)) begin
                        n_ok    = 1'b1;
                        n_state = S_PACK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PACK: begin
                // slot read at r_pidx lands at r_wr_ptr <= r_pidx: never overwrites unread data
                if (r_pv) begin
                    if (drop) begin
                        if (r_kind == KIND_REMOVE) n_ok = 1'b1;
                    end else begin
                        we       = 1'b1;
                        n_wr_ptr = r_wr_ptr + 1'b1;
                    end
                end
                if (pass_end) begin
                    n_fill  = r_wr_ptr;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rdata <= mem[rd_addr];
        if (we) mem[waddr] <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_tid       <= n_tid;
        r_rd_ptr    <= n_rd_ptr;
        r_wr_ptr    <= n_wr_ptr;
        r_pidx      <= n_pidx;
        r_best_idx  <= n_best_idx;
        r_best_prio <= n_best_prio;
        r_best_task <= n_best_task;
        r_best_data <= n_best_data;
        r_ok        <= n_ok;
    end

    logic ext_ok;
    assign ext_ok = (r_kind == KIND_EXTRACT) && r_ok;

    assign o_busy                   = (r_state != S_IDLE);
    assign o_res.valid              = (r_state == S_DONE);
    assign o_res.item.ok            = r_ok;
    assign o_res.item.out_task      = ext_ok ? r_best_task : '0;
    assign o_res.item.out_data      = ext_ok ? WORD_W'(r_best_data) : '0;
    assign o_res.item.occupancy     = OCC_W'(r_fill);

endmodule

@@ rtl/task_priority_queue.sv @@
// Top level of the task priority queue: APB capacity register, engine, result register.
// Depends on tpq_pkg and tpq_engine.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-----------------------
//  in       | in        | i_in_valid / o_in_stall        | i_in_item  (t_in_item)
//  out      | out       | o_out_valid / i_out_stall      | o_out_item (t_out_item)
//  config   | in        | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One item at a time; all entry reads go through a single memory read port.
// Insert writes its slot directly. Query makes one search pass, remove one compaction pass.
// Extract makes a search pass, then a compaction pass; on an empty queue it skips compaction.
// A result moves into the output register, so the next item is taken while it waits;
// a stalled output register holds the next result in the engine and adds its stall cycles.
// Reset (synchronous, active low) empties the queue and sets capacity to 16;
// the entry memory itself is not cleared, only slots below the fill are read.
`timescale 1ns / 1ps

module task_priority_queue #(
    parameter int DEPTH     = tpq_pkg::DEPTH_DEF,
    parameter int DATA_BITS = tpq_pkg::DATA_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tpq_pkg::t_in_item             i_in_item,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tpq_pkg::t_out_item            o_out_item,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpq_pkg::APB_AW-1:0]    paddr,
    input  logic [tpq_pkg::APB_DW-1:0]    pwdata,
    output logic [tpq_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import tpq_pkg::*;

    logic [CAP_W-1:0] r_cap;
    logic             cfg_wr;
    logic             busy;
    logic             res_ready;
    t_result          res;
    logic             r_out_valid;
    t_out_item        r_out_item;

    // capacity register: word index in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) prdata = APB_DW'(r_cap);
    end

    // engine holds the queue; it only finishes an item when the result slot can take it
    assign res_ready = !r_out_valid || !i_out_stall;

    tpq_engine #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_busy      (busy),
        .i_cap       (r_cap),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign o_in_stall = busy;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) r_out_item <= res.item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/tpq_checker.sv @@
// Port-level checks for the task priority queue, bound to the top level.
// Depends on tpq_pkg and task_priority_queue.
`timescale 1ns / 1ps

module tpq_checker #(
    parameter int DEPTH = tpq_pkg::DEPTH_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input tpq_pkg::t_out_item   o_out_item
);
    import tpq_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // failed operations report no task and no data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.ok |-> o_out_item.out_task == '0 && o_out_item.out_data == '0)
        else $error("failed result carries task or data");

    // occupancy never exceeds the built depth
    a_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_item.occupancy) <= 32'(DEPTH)))
        else $error("occupancy above depth");

    // reset leaves no result pending and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state after reset not idle");

endmodule

bind task_priority_queue tpq_checker #(.DEPTH(DEPTH)) u_tpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
